// ----- hdl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue with remove-maximum.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_MAX    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

endpackage

// ----- hdl/dq_if.sv -----
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channels: request (command, value) and response
// (result_value, status).
// ----------------------------------------------------------------------------
interface dq_req_if
  import dq_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface dq_rsp_if
  import dq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ----- hdl/deque_with_pop_max_top.sv -----
// Sequencing: push, failed request or unused command go straight to the finish state; end
// pops first take one registered memory read. Remove-maximum scans every entry, then
// shifts each entry past the maximum (read, then write), then finishes.
// Throughput: one request at a time; the next transfer is taken once the sequencer is
// back in idle, even while the previous result still waits at the output register.
// Reset (rst_n low, synchronous): pointers, fill count, sequencer and output valid clear.
// ----------------------------------------------------------------------------
// deque_with_pop_max_top
// Bounded deque over a ring memory of DEPTH signed 32-bit entries, with
// push/pop at both ends and removal of the largest value.
// ----------------------------------------------------------------------------
module deque_with_pop_max_top
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dq_req_if.sink    in_req,
  dq_rsp_if.source  out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // ring index width
  localparam int CW = $clog2(DEPTH + 1);                  // count width, holds DEPTH

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,      // waiting for end-pop read data
    ST_SCAN,    // streaming reads back to front, tracking the maximum
    ST_SH_RD,   // shift step: read the entry one place nearer the front
    ST_SH_WR,   // shift step: write it one place toward the back
    ST_FIN      // result ready, waiting for a free output register
  } state_t;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] i);
    ring_inc = (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] i);
    ring_dec = (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Ring storage: one write port, one read port, registered read data.
  // Only read data of occupied entries is ever used, so the store needs no reset.
  // --------------------------------------------------------------------------
  data_t          mem [DEPTH];
  data_t          rd_data_r;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  data_t          mem_wd;
  logic [AW-1:0]  mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_t         state_r,     state_nxt;
  logic [AW-1:0]  back_r,      back_nxt;     // index of the back element
  logic [AW-1:0]  front_r,     front_nxt;    // one past the front element
  logic [CW-1:0]  fill_r,      fill_nxt;
  // Scan / shift cursor: rptr_r is the ring address of element k_r
  logic [AW-1:0]  rptr_r,      rptr_nxt;
  logic [CW-1:0]  k_r,         k_nxt;
  data_t          best_val_r,  best_val_nxt;
  logic [AW-1:0]  best_ptr_r,  best_ptr_nxt;
  logic [CW-1:0]  best_k_r,    best_k_nxt;
  // Pending result and output register
  data_t          res_val_r,   res_val_nxt;
  status_t        res_st_r,    res_st_nxt;
  logic           out_valid_r, out_valid_nxt;
  data_t          out_val_r,   out_val_nxt;
  status_t        out_st_r,    out_st_nxt;

  cmd_t           cmd;
  logic           scan_upd;
  logic           scan_last;
  data_t          scan_val;
  logic [AW-1:0]  scan_ptr;
  logic [CW-1:0]  scan_k;

  assign cmd = cmd_t'(in_req.command);

  // Running maximum: first element seeds it, later ones replace it only when
  // strictly greater, so equal maxima keep the one nearest the back.
  assign scan_upd  = (k_r == '0) || (rd_data_r > best_val_r);
  assign scan_val  = scan_upd ? rd_data_r : best_val_r;
  assign scan_ptr  = scan_upd ? rptr_r    : best_ptr_r;
  assign scan_k    = scan_upd ? k_r       : best_k_r;
  assign scan_last = (k_r == fill_r - CW'(1));

  always_comb begin
    state_nxt     = state_r;
    back_nxt      = back_r;
    front_nxt     = front_r;
    fill_nxt      = fill_r;
    rptr_nxt      = rptr_r;
    k_nxt         = k_r;
    best_val_nxt  = best_val_r;
    best_ptr_nxt  = best_ptr_r;
    best_k_nxt    = best_k_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_wa        = back_r;
    mem_wd        = in_req.value;
    mem_ra        = back_r;

    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          res_val_nxt = '0;
          res_st_nxt  = STAT_OK;
          state_nxt   = ST_FIN;
          case (cmd)
            CMD_PUSH_BACK: begin
              if (fill_r == CW'(DEPTH)) begin
                res_st_nxt = STAT_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = ring_dec(back_r);
                back_nxt = ring_dec(back_r);
                fill_nxt = fill_r + CW'(1);
              end
            end
            CMD_PUSH_FRONT: begin
              if (fill_r == CW'(DEPTH)) begin
                res_st_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = front_r;
                front_nxt = ring_inc(front_r);
                fill_nxt  = fill_r + CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (fill_r == '0) begin
                res_st_nxt = STAT_EMPTY;
              end else begin
                mem_ra    = back_r;
                back_nxt  = ring_inc(back_r);
                fill_nxt  = fill_r - CW'(1);
                state_nxt = ST_RD;
              end
            end
            CMD_POP_FRONT: begin
              if (fill_r == '0) begin
                res_st_nxt = STAT_EMPTY;
              end else begin
                mem_ra    = ring_dec(front_r);
                front_nxt = ring_dec(front_r);
                fill_nxt  = fill_r - CW'(1);
                state_nxt = ST_RD;
              end
            end
            CMD_POP_MAX: begin
              if (fill_r == '0) begin
                res_st_nxt = STAT_EMPTY;
              end else begin
                mem_ra    = back_r;
                rptr_nxt  = back_r;
                k_nxt     = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              // unused command: no state change, ok with zero value
            end
          endcase
        end
      end

      ST_RD: begin
        res_val_nxt = rd_data_r;
        state_nxt   = ST_FIN;
      end

      ST_SCAN: begin
        best_val_nxt = scan_val;
        best_ptr_nxt = scan_ptr;
        best_k_nxt   = scan_k;
        if (scan_last) begin
          rptr_nxt  = scan_ptr;
          k_nxt     = scan_k;
          state_nxt = ST_SH_RD;
        end else begin
          mem_ra    = ring_inc(rptr_r);
          rptr_nxt  = ring_inc(rptr_r);
          k_nxt     = k_r + CW'(1);
        end
      end

      ST_SH_RD: begin
        if ((k_r + CW'(1)) >= fill_r) begin
          front_nxt   = ring_dec(front_r);
          fill_nxt    = fill_r - CW'(1);
          res_val_nxt = best_val_r;
          res_st_nxt  = STAT_OK;
          state_nxt   = ST_FIN;
        end else begin
          mem_ra    = ring_inc(rptr_r);
          state_nxt = ST_SH_WR;
        end
      end

      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_wa    = rptr_r;
        mem_wd    = rd_data_r;
        rptr_nxt  = ring_inc(rptr_r);
        k_nxt     = k_r + CW'(1);
        state_nxt = ST_SH_RD;
      end

      ST_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      back_r      <= '0;
      front_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      back_r      <= back_nxt;
      front_r     <= front_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rptr_r     <= rptr_nxt;
    k_r        <= k_nxt;
    best_val_r <= best_val_nxt;
    best_ptr_r <= best_ptr_nxt;
    best_k_r   <= best_k_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
  end

  // Requests are taken only by the idle sequencer
  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_value = out_val_r;
  assign out_rsp.status       = out_st_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ((fill_r == '0) || (fill_r == CW'(DEPTH))) == (front_r == back_r))
    else $error("ring pointers disagree with fill count");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (k_r < fill_r))
    else $error("scan ran past the occupied entries");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while busy");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && !out_rsp.ready)) |-> (state_r == ST_FIN))
    else $error("result loaded outside finish state");

endmodule

// ----- sim/deque_with_pop_max_top_tb.sv -----
// ----------------------------------------------------------------------------
// deque_with_pop_max_top_tb
// Self-checking bench for the bounded deque with remove-maximum. Requests are
// sent over the request channel in random bursts while the response channel
// stalls on its own pattern. A local deque model predicts every response,
// and each response transfer is checked field by field against it.
// ----------------------------------------------------------------------------
module deque_with_pop_max_top_tb;
  import dq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  // Slack covers a worst-case remove-maximum: scan, shift of every entry, output.
  localparam int DRAIN_SLACK  = 3 * DEPTH + 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    data_t   value;
    status_t status;
  } dq_response_t;

  logic clk;
  logic rst_n;

  dq_req_if req_if ();
  dq_rsp_if rsp_if ();

  deque_with_pop_max_top #(
    .DEPTH (DEPTH)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Local copy of the deque: ring, back/front indexes and fill level.
  data_t ring_store [DEPTH];
  int    back_idx;
  int    front_idx;
  int    occupancy;

  dq_response_t pending_responses [$];
  int           mismatch_count;
  int           cycle_count;

  // Sender pacing and receiver hold-off request.
  int burst_left;
  int max_gap;
  bit sender_gaps;
  int hold_request;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic int ring_pos(input int k);
    return (back_idx + k) % DEPTH;
  endfunction

  function automatic dq_response_t predict_response(input logic [CMD_W-1:0] op,
                                                    input data_t val);
    dq_response_t r;
    int best;
    r.value  = '0;
    r.status = STAT_OK;
    if (op == CMD_PUSH_BACK || op == CMD_PUSH_FRONT) begin
      if (occupancy >= DEPTH) begin
        r.status = STAT_FULL;
      end else if (op == CMD_PUSH_BACK) begin
        back_idx = (back_idx + DEPTH - 1) % DEPTH;
        ring_store[back_idx] = val;
        occupancy++;
      end else begin
        ring_store[front_idx] = val;
        front_idx = (front_idx + 1) % DEPTH;
        occupancy++;
      end
    end else if (op == CMD_POP_BACK || op == CMD_POP_FRONT || op == CMD_POP_MAX) begin
      if (occupancy == 0) begin
        r.status = STAT_EMPTY;
      end else if (op == CMD_POP_BACK) begin
        r.value  = ring_store[back_idx];
        back_idx = (back_idx + 1) % DEPTH;
        occupancy--;
      end else if (op == CMD_POP_FRONT) begin
        front_idx = (front_idx + DEPTH - 1) % DEPTH;
        r.value   = ring_store[front_idx];
        occupancy--;
      end else begin
        // first strict maximum seen from the back wins
        best    = 0;
        r.value = ring_store[ring_pos(0)];
        for (int k = 1; k < occupancy; k++) begin
          if (ring_store[ring_pos(k)] > r.value) begin
            r.value = ring_store[ring_pos(k)];
            best    = k;
          end
        end
        // close the gap: entries beyond it move one place toward the back
        for (int k = best; k + 1 < occupancy; k++)
          ring_store[ring_pos(k)] = ring_store[ring_pos(k + 1)];
        front_idx = (front_idx + DEPTH - 1) % DEPTH;
        occupancy--;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[cycle %0d] mismatch: %s", cycle_count, msg);
  endtask

  initial begin : response_checker
    dq_response_t want;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_responses.size() == 0) begin
          report_mismatch($sformatf("response with nothing pending (value %0d status %0d)",
                                    rsp_if.result_value, rsp_if.status));
        end else begin
          want = pending_responses.pop_front();
          if (rsp_if.result_value !== want.value)
            report_mismatch($sformatf("result_value %0d, predicted %0d",
                                      rsp_if.result_value, want.value));
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      rsp_if.status, want.status));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls on a pattern of its own, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : response_receiver
    int mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    int phase;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    phase     = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      phase = (phase + 1) % 7;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= (phase < 3);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("deque_with_pop_max_top_tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offers one request and waits for its transfer; valid stays high so a
  // following request can go out back to back.
  task automatic issue_request(input logic [CMD_W-1:0] op, input data_t val);
    req_if.valid   <= 1'b1;
    req_if.command <= op;
    req_if.value   <= val;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_responses.push_back(predict_response(op, val));
  endtask

  task automatic idle_cycles(input int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // One request, then a gap if the current burst is used up and gaps are enabled.
  task automatic send_item(input logic [CMD_W-1:0] op, input data_t val);
    issue_request(op, val);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (sender_gaps)
        idle_cycles($urandom_range(1, max_gap));
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Sender pause: nothing offered until every response is back.
  task automatic wait_for_responses();
    req_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Values biased toward extremes and a few small ones so that equal
  // maxima turn up often.
  function automatic data_t random_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return data_t'($signed($urandom_range(0, 6)) - 3);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] unused_command();
    return CMD_W'($urandom_range(5, 7));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // pops on an empty deque, then commands the block ignores
    send_item(CMD_POP_BACK,  data_t'($urandom));
    send_item(CMD_POP_FRONT, data_t'($urandom));
    send_item(CMD_POP_MAX,   data_t'($urandom));
    send_item(3'd5, 32'sh7fff_ffff);
    send_item(3'd6, 32'sh8000_0000);
    send_item(3'd7, -32'sd1);
    // extremes at both ends: back..front = 0, max, min, -1
    send_item(CMD_PUSH_BACK,  32'sh7fff_ffff);
    send_item(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_item(CMD_PUSH_BACK,  32'sd0);
    send_item(CMD_PUSH_FRONT, -32'sd1);
    send_item(CMD_POP_MAX,    data_t'($urandom));
    send_item(CMD_POP_FRONT,  data_t'($urandom));
    send_item(CMD_POP_BACK,   data_t'($urandom));
    send_item(CMD_POP_MAX,    data_t'($urandom));
    // equal maxima: back..front = 7, 1, 7; the back one must go
    send_item(CMD_PUSH_FRONT, 32'sd7);
    send_item(CMD_PUSH_FRONT, 32'sd1);
    send_item(CMD_PUSH_FRONT, 32'sd7);
    send_item(CMD_POP_MAX,    data_t'($urandom));
    send_item(CMD_POP_BACK,   data_t'($urandom));
    send_item(CMD_POP_FRONT,  data_t'($urandom));
    // an ignored command must leave a non-empty deque alone
    send_item(CMD_PUSH_BACK,  32'sh5555_5555);
    send_item(3'd7,           32'shaaaa_aaaa);
    send_item(CMD_POP_FRONT,  data_t'($urandom));
  endtask

  // Fill to capacity from both ends, push into a full deque, then empty it.
  task automatic test_capacity();
    for (int i = 0; i < DEPTH; i++)
      send_item($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_value());
    send_item(CMD_PUSH_BACK,  random_value());
    send_item(CMD_PUSH_FRONT, random_value());
    for (int i = 0; i < DEPTH; i++) begin
      case ($urandom_range(0, 2))
        0:       send_item(CMD_POP_BACK,  data_t'($urandom));
        1:       send_item(CMD_POP_FRONT, data_t'($urandom));
        default: send_item(CMD_POP_MAX,   data_t'($urandom));
      endcase
    end
    send_item(CMD_POP_MAX, data_t'($urandom));
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so
  // the output register fills and the request channel stalls.
  task automatic test_hold_off();
    hold_request++;
    for (int i = 0; i < 24; i++)
      issue_request(i < 14 ? CMD_PUSH_FRONT : CMD_POP_MAX, random_value());
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int phase_len;
    int push_pct;
    int r;
    logic [CMD_W-1:0] op;
    sent = 0;
    while (sent < n_items) begin
      phase_len   = $urandom_range(20, 100);
      sender_gaps = ($urandom_range(0, 3) != 0);
      max_gap     = $urandom_range(1, 16);
      case ($urandom_range(0, 4))
        0:       push_pct = 10;
        1:       push_pct = 30;
        2:       push_pct = 50;
        3:       push_pct = 70;
        default: push_pct = 90;
      endcase
      for (int i = 0; i < phase_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          op = unused_command();
        else if (r < 3 + push_pct)
          op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else begin
          case ($urandom_range(0, 3))
            0:       op = CMD_POP_BACK;
            1:       op = CMD_POP_FRONT;
            default: op = CMD_POP_MAX;
          endcase
        end
        send_item(op, random_value());
        if (op <= CMD_POP_MAX)
          sent++;
      end
      if ($urandom_range(0, 7) == 0)
        wait_for_responses();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    mismatch_count = 0;
    hold_request   = 0;
    burst_left     = 0;
    max_gap        = 4;
    sender_gaps    = 1'b1;
    back_idx       = 0;
    front_idx      = 0;
    occupancy      = 0;
    for (int i = 0; i < DEPTH; i++)
      ring_store[i] = '0;

    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_PUSH_BACK;
    req_if.value   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity();
    wait_for_responses();
    test_random(700);
    test_hold_off();
    wait_for_responses();
    test_random(850);

    wait_for_responses();
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("deque_with_pop_max_top_tb OK");
    end else begin
      $display("deque_with_pop_max_top_tb NOT OK");
    end
    $finish;
  end

endmodule
